/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Common form: clock clk, reset arst_n.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLKD(lbl, clk, arst_n, prop, msg)

`endif

/* src/uvs_pkg.sv */
package uvs_pkg;

	localparam int CNT_W = 9;
	localparam int IDX_W = 8;
	localparam int VTX_W = 3;
	localparam int POS_W = 15;
	localparam int NRM_W = 16;
	localparam int FRAC_BITS = 14;

	localparam int MAX_STEPS = 256;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

	localparam logic [VTX_W-1:0] VTX_FIRST = 3'd0;
	localparam logic [VTX_W-1:0] VTX_LAST = 3'd5;

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAT_STEPS = 2'd0,
		CFG_LON_STEPS = 2'd1
	} cfg_reg_t;

	localparam logic [CNT_W-1:0] LAT_STEPS_RST = 9'd8;
	localparam logic [CNT_W-1:0] LON_STEPS_RST = 9'd8;

	// Phase: 32-bit fraction of a turn
	localparam int PHASE_W = 32;
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_LAT = 1 + PHASE_W / DIV_STEP_BITS;

	// Q30 trig
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;
	localparam int TAYLOR_TERMS = 5;
	localparam int SIN_DIV [TAYLOR_TERMS] = '{110, 72, 42, 20, 6};
	localparam int COS_DIV [TAYLOR_TERMS] = '{90, 56, 30, 12, 2};
	localparam int TRIG_LAT = 3 + 2 * (TAYLOR_TERMS - 1) + 2;

endpackage

/* src/uvs_if.sv */
interface uvs_tile_if;
	logic valid;
	logic ready;
	logic [uvs_pkg::IDX_W-1:0] lat_index;
	logic [uvs_pkg::IDX_W-1:0] lon_index;

	modport source (output valid, output lat_index, output lon_index, input ready);
	modport sink (input valid, input lat_index, input lon_index, output ready);
endinterface

interface uvs_vertex_if;
	logic valid;
	logic ready;
	logic [uvs_pkg::VTX_W-1:0] vertex_number;
	logic signed [uvs_pkg::POS_W-1:0] pos_x;
	logic signed [uvs_pkg::POS_W-1:0] pos_y;
	logic signed [uvs_pkg::POS_W-1:0] pos_z;
	logic signed [uvs_pkg::NRM_W-1:0] norm_x;
	logic signed [uvs_pkg::NRM_W-1:0] norm_y;
	logic signed [uvs_pkg::NRM_W-1:0] norm_z;
	logic last_vertex;
	logic index_error;

	modport source (output valid, output vertex_number, output pos_x, output pos_y,
		output pos_z, output norm_x, output norm_y, output norm_z, output last_vertex,
		output index_error, input ready);
	modport sink (input valid, input vertex_number, input pos_x, input pos_y,
		input pos_z, input norm_x, input norm_y, input norm_z, input last_vertex,
		input index_error, output ready);
endinterface

/* src/uv_sphere_tile_vertex_generator_unit.sv */
// UV sphere tile vertex generator. Each accepted tile request (latitude band,
// longitude wedge) yields six vertex transfers, one per cycle: top-left,
// bottom-left, bottom-right, top-left, bottom-right, top-right, with
// last_vertex on the sixth. Positions lie on a sphere of radius one half,
// normals are unit length, both signed with 14 fraction bits. A request
// whose index is at or beyond its count (counts above 256 act as 256, a
// count of 0 rejects everything) yields a single transfer with index_error
// and last_vertex set and all coordinates zero. Throughput is one vertex per
// cycle while the vertex side does not stall; the vertex issue stage that
// walks the six corners (one job for a rejected request) sets this. A
// request can be taken on the cycle its predecessor's last vertex issues.
// From request transfer to first vertex valid the data passes through a
// 9-stage phase divider, a 13-stage sine/cosine pipeline, a product stage
// and the output register. A stall on the vertex side freezes the whole
// pipeline; nothing is dropped or repeated. lat_steps/lon_steps are written
// through cfg_we/cfg_index/cfg_data and reset to 8; write them only while
// the block is empty.
module uv_sphere_tile_vertex_generator_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [uvs_pkg::CNT_W-1:0] cfg_data,
	uvs_tile_if.sink tile,
	uvs_vertex_if.source vertex
);

	localparam int PIPE_LEN = uvs_pkg::DIV_LAT + uvs_pkg::TRIG_LAT + 1;
	localparam int F = uvs_pkg::FRAC_BITS;

	typedef struct packed {
		logic [uvs_pkg::VTX_W-1:0] vtx;
		logic last;
		logic err;
	} side_t;

	// round to nearest, ties away from zero
	function automatic logic [63:0] round_sh(input logic signed [63:0] v,
		input logic [5:0] sh);
		logic [63:0] m;
		logic [63:0] half;
		half = 64'd1 << (sh - 6'd1);
		m = v[63] ? 64'd0 - 64'(v) : 64'(v);
		m = (m + half) >> sh;
		return v[63] ? 64'd0 - m : m;
	endfunction

	// ---------------- configuration registers ----------------
	logic [uvs_pkg::CNT_W-1:0] lat_steps_q;
	logic [uvs_pkg::CNT_W-1:0] lon_steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_steps_q <= uvs_pkg::LAT_STEPS_RST;
			lon_steps_q <= uvs_pkg::LON_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				uvs_pkg::CFG_LAT_STEPS: lat_steps_q <= cfg_data;
				uvs_pkg::CFG_LON_STEPS: lon_steps_q <= cfg_data;
				default: ;	// unknown index: ignored
			endcase
		end
	end

	// counts beyond the supported maximum act as the maximum
	logic [uvs_pkg::CNT_W-1:0] lat_eff;
	logic [uvs_pkg::CNT_W-1:0] lon_eff;
	assign lat_eff = (lat_steps_q > uvs_pkg::MAX_CNT) ? uvs_pkg::MAX_CNT : lat_steps_q;
	assign lon_eff = (lon_steps_q > uvs_pkg::MAX_CNT) ? uvs_pkg::MAX_CNT : lon_steps_q;

	// ---------------- global advance ----------------
	// Every stage moves together; the output register frees the pipe.
	logic out_vld_q;
	logic en;
	assign en = !out_vld_q || vertex.ready;

	// ---------------- vertex issue ----------------
	// Holds one tile and walks its six corners, one job per cycle while en is high.
	logic busy_q;
	logic [uvs_pkg::VTX_W-1:0] cnt_q;
	logic [uvs_pkg::IDX_W-1:0] lat_idx_q;
	logic [uvs_pkg::IDX_W-1:0] lon_idx_q;
	logic err_w;
	logic last_job;
	logic take_w;

	assign err_w = ({1'b0, lat_idx_q} >= lat_eff) || ({1'b0, lon_idx_q} >= lon_eff);
	assign last_job = err_w || (cnt_q == uvs_pkg::VTX_LAST);
	assign take_w = en && (!busy_q || last_job);
	assign tile.ready = take_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= uvs_pkg::VTX_FIRST;
		end else if (en) begin
			if (!busy_q || last_job) begin
				busy_q <= tile.valid;
				cnt_q <= uvs_pkg::VTX_FIRST;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_w && tile.valid) begin
			lat_idx_q <= tile.lat_index;
			lon_idx_q <= tile.lon_index;
		end
	end

	// corner choice: bottom edge for 1, 2, 4; right edge for 2, 4, 5
	logic use_bot;
	logic use_right;

	always_comb begin
		case (cnt_q) inside
			3'd1, 3'd2, 3'd4: use_bot = 1'b1;
			default: use_bot = 1'b0;
		endcase
		case (cnt_q) inside
			3'd2, 3'd4, 3'd5: use_right = 1'b1;
			default: use_right = 1'b0;
		endcase
	end

	logic [uvs_pkg::CNT_W-1:0] lat_num;
	logic [uvs_pkg::CNT_W-1:0] lon_num;
	assign lat_num = {1'b0, lat_idx_q} + (use_bot ? 9'd1 : 9'd0);
	assign lon_num = {1'b0, lon_idx_q} + (use_right ? 9'd1 : 9'd0);

	side_t side_w;
	assign side_w = '{vtx: err_w ? uvs_pkg::VTX_FIRST : cnt_q, last: last_job, err: err_w};

	// ---------------- side band: valid and tags beside the datapath ----------------
	logic side_vld_s [PIPE_LEN];
	side_t side_s [PIPE_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LEN; k++) side_vld_s[k] <= 1'b0;
		end else if (en) begin
			side_vld_s[0] <= busy_q;
			for (int k = 1; k < PIPE_LEN; k++) side_vld_s[k] <= side_vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_w;
			for (int k = 1; k < PIPE_LEN; k++) side_s[k] <= side_s[k-1];
		end
	end

	// ---------------- phases ----------------
	logic [uvs_pkg::PHASE_W:0] phi_quo;
	logic [uvs_pkg::PHASE_W:0] theta_quo;

	uvs_phase_div u_div_phi (
		.clk(clk),
		.en(en),
		.num(lat_num),
		.den(lat_eff),
		.quo(phi_quo)
	);

	uvs_phase_div u_div_theta (
		.clk(clk),
		.en(en),
		.num(lon_num),
		.den(lon_eff),
		.quo(theta_quo)
	);

	// phi spans half a turn; theta a full turn offset by a quarter
	logic [uvs_pkg::PHASE_W-1:0] phi_phase;
	logic [uvs_pkg::PHASE_W-1:0] theta_phase;
	assign phi_phase = phi_quo[uvs_pkg::PHASE_W:1];
	assign theta_phase = theta_quo[uvs_pkg::PHASE_W-1:0] + 32'h4000_0000;

	// ---------------- sine / cosine ----------------
	logic signed [31:0] phi_sin;
	logic signed [31:0] phi_cos;
	logic signed [31:0] theta_sin;
	logic signed [31:0] theta_cos;

	uvs_trig u_trig_phi (
		.clk(clk),
		.en(en),
		.phase(phi_phase),
		.sin_q(phi_sin),
		.cos_q(phi_cos)
	);

	uvs_trig u_trig_theta (
		.clk(clk),
		.en(en),
		.phase(theta_phase),
		.sin_q(theta_sin),
		.cos_q(theta_cos)
	);

	// ---------------- products (Q60 x/z, Q30 y) ----------------
	logic signed [63:0] px_s;
	logic signed [63:0] pz_s;
	logic signed [63:0] py_s;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s <= 64'(phi_sin) * 64'(theta_sin);
			pz_s <= 64'(phi_sin) * 64'(theta_cos);
			py_s <= 64'(phi_cos);
		end
	end

	// ---------------- rounding and output register ----------------
	side_t side_last;
	assign side_last = side_s[PIPE_LEN-1];

	logic [uvs_pkg::VTX_W-1:0] vnum_q;
	logic signed [uvs_pkg::POS_W-1:0] pos_x_q;
	logic signed [uvs_pkg::POS_W-1:0] pos_y_q;
	logic signed [uvs_pkg::POS_W-1:0] pos_z_q;
	logic signed [uvs_pkg::NRM_W-1:0] norm_x_q;
	logic signed [uvs_pkg::NRM_W-1:0] norm_y_q;
	logic signed [uvs_pkg::NRM_W-1:0] norm_z_q;
	logic last_q;
	logic err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_vld_s[PIPE_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vnum_q <= side_last.vtx;
			last_q <= side_last.last;
			err_q <= side_last.err;
			if (side_last.err) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				norm_x_q <= '0;
				norm_y_q <= '0;
				norm_z_q <= '0;
			end else begin
				// position is half the unit vector: one more bit of shift
				pos_x_q <= uvs_pkg::POS_W'(round_sh(px_s, 6'(61 - F)));
				pos_y_q <= uvs_pkg::POS_W'(round_sh(py_s, 6'(31 - F)));
				pos_z_q <= uvs_pkg::POS_W'(round_sh(pz_s, 6'(61 - F)));
				norm_x_q <= uvs_pkg::NRM_W'(round_sh(px_s, 6'(60 - F)));
				norm_y_q <= uvs_pkg::NRM_W'(round_sh(py_s, 6'(30 - F)));
				norm_z_q <= uvs_pkg::NRM_W'(round_sh(pz_s, 6'(60 - F)));
			end
		end
	end

	assign vertex.valid = out_vld_q;
	assign vertex.vertex_number = vnum_q;
	assign vertex.pos_x = pos_x_q;
	assign vertex.pos_y = pos_y_q;
	assign vertex.pos_z = pos_z_q;
	assign vertex.norm_x = norm_x_q;
	assign vertex.norm_y = norm_y_q;
	assign vertex.norm_z = norm_z_q;
	assign vertex.last_vertex = last_q;
	assign vertex.index_error = err_q;

endmodule

/* src/uvs_phase_div.sv */
// Pipelined long division: quo = floor(num * 2^32 / den), num <= den.
// quo[32] is the integer bit, quo[31:0] the fraction.
module uvs_phase_div (
	input logic clk,
	input logic en,
	input logic [uvs_pkg::CNT_W-1:0] num,
	input logic [uvs_pkg::CNT_W-1:0] den,
	output logic [uvs_pkg::PHASE_W:0] quo
);

	localparam int NSTG = uvs_pkg::PHASE_W / uvs_pkg::DIV_STEP_BITS;

	logic [uvs_pkg::CNT_W-1:0] rem_s [NSTG+1];
	logic [uvs_pkg::CNT_W-1:0] den_s [NSTG+1];
	logic [uvs_pkg::PHASE_W-1:0] frac_s [NSTG+1];
	logic int_s [NSTG+1];

	logic ge_w;
	assign ge_w = num >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ge_w ? num - den : num;
			den_s[0] <= den;
			frac_s[0] <= '0;
			int_s[0] <= ge_w;
		end
	end

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic [uvs_pkg::CNT_W-1:0] rem_w;
		logic [uvs_pkg::PHASE_W-1:0] frac_w;

		always_comb begin
			logic [uvs_pkg::CNT_W:0] r2;
			rem_w = rem_s[g];
			frac_w = frac_s[g];
			for (int b = 0; b < uvs_pkg::DIV_STEP_BITS; b++) begin
				r2 = {rem_w, 1'b0};
				if (r2 >= {1'b0, den_s[g]}) begin
					rem_w = uvs_pkg::CNT_W'(r2 - {1'b0, den_s[g]});
					frac_w = {frac_w[uvs_pkg::PHASE_W-2:0], 1'b1};
				end else begin
					rem_w = uvs_pkg::CNT_W'(r2);
					frac_w = {frac_w[uvs_pkg::PHASE_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_w;
				den_s[g+1] <= den_s[g];
				frac_s[g+1] <= frac_w;
				int_s[g+1] <= int_s[g];
			end
		end
	end

	assign quo = {int_s[NSTG], frac_s[NSTG]};

endmodule

/* src/uvs_trig.sv */
// Q30 sine and cosine of a 32-bit phase, octant folding plus nested Taylor
// series; at most two multiplies per stage, constant divides by reciprocal multiply.
module uvs_trig (
	input logic clk,
	input logic en,
	input logic [uvs_pkg::PHASE_W-1:0] phase,
	output logic signed [31:0] sin_q,
	output logic signed [31:0] cos_q
);

	localparam int NSTEP = uvs_pkg::TAYLOR_TERMS - 1;

	typedef struct packed {
		logic [29:0] x;
		logic [29:0] x2;
		logic [1:0] quad;
		logic swap;
	} carry_t;

	// fold to an eighth of a turn, scale to radians
	logic [29:0] r_w;
	logic [29:0] a_w;
	logic swap_w;
	logic [60:0] xp_s1;
	logic [1:0] quad_s1;
	logic swap_s1;

	assign r_w = phase[29:0];
	assign swap_w = r_w > 30'h2000_0000;
	assign a_w = swap_w ? 30'(uvs_pkg::Q30_ONE - {1'b0, r_w}) : r_w;

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s1 <= 61'(a_w) * 61'(uvs_pkg::HALF_PI_Q30);
			quad_s1 <= phase[31:30];
			swap_s1 <= swap_w;
		end
	end

	// x squared
	logic [29:0] x_w;
	logic [29:0] x_s2;
	logic [59:0] xx_s2;
	logic [1:0] quad_s2;
	logic swap_s2;

	assign x_w = xp_s1[59:30];

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= 60'(x_w) * 60'(x_w);
			x_s2 <= x_w;
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
		end
	end

	// quotient products: index 0 from x2, index k+1 from step k
	logic [61:0] qs_b [NSTEP+1];
	logic [61:0] qc_b [NSTEP+1];
	carry_t carry_b [NSTEP+1];
	logic [60:0] ps_a [NSTEP];
	logic [60:0] pc_a [NSTEP];
	carry_t carry_a [NSTEP];

	localparam int SH0 = 30 + $clog2(uvs_pkg::SIN_DIV[0]);
	localparam int CH0 = 30 + $clog2(uvs_pkg::COS_DIV[0]);
	localparam logic [31:0] SM0 = 32'(((64'd1 << SH0) / uvs_pkg::SIN_DIV[0]) + 64'd1);
	localparam logic [31:0] CM0 = 32'(((64'd1 << CH0) / uvs_pkg::COS_DIV[0]) + 64'd1);

	logic [29:0] x2_w;
	assign x2_w = xx_s2[59:30];

	always_ff @(posedge clk) begin
		if (en) begin
			qs_b[0] <= 62'(x2_w) * 62'(SM0);
			qc_b[0] <= 62'(x2_w) * 62'(CM0);
			carry_b[0] <= '{x: x_s2, x2: x2_w, quad: quad_s2, swap: swap_s2};
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int SHA = 30 + $clog2(uvs_pkg::SIN_DIV[k]);
		localparam int CHA = 30 + $clog2(uvs_pkg::COS_DIV[k]);
		localparam int SHB = 30 + $clog2(uvs_pkg::SIN_DIV[k+1]);
		localparam int CHB = 30 + $clog2(uvs_pkg::COS_DIV[k+1]);
		localparam logic [31:0] SMB =
			32'(((64'd1 << SHB) / uvs_pkg::SIN_DIV[k+1]) + 64'd1);
		localparam logic [31:0] CMB =
			32'(((64'd1 << CHB) / uvs_pkg::COS_DIV[k+1]) + 64'd1);

		logic [30:0] ts_w;
		logic [30:0] tc_w;

		// t = 1 - x2 * t_prev / c
		assign ts_w = uvs_pkg::Q30_ONE - 31'(qs_b[k] >> SHA);
		assign tc_w = uvs_pkg::Q30_ONE - 31'(qc_b[k] >> CHA);

		always_ff @(posedge clk) begin
			if (en) begin
				ps_a[k] <= 61'(carry_b[k].x2) * 61'(ts_w);
				pc_a[k] <= 61'(carry_b[k].x2) * 61'(tc_w);
				carry_a[k] <= carry_b[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qs_b[k+1] <= 62'(ps_a[k][59:30]) * 62'(SMB);
				qc_b[k+1] <= 62'(pc_a[k][59:30]) * 62'(CMB);
				carry_b[k+1] <= carry_a[k];
			end
		end
	end

	// last term: sin = x * t, cos = t
	localparam int SHF = 30 + $clog2(uvs_pkg::SIN_DIV[NSTEP]);
	localparam int CHF = 30 + $clog2(uvs_pkg::COS_DIV[NSTEP]);

	logic [30:0] tsf_w;
	logic [60:0] s_sf;
	logic [30:0] c_sf;
	logic [1:0] quad_sf;
	logic swap_sf;

	assign tsf_w = uvs_pkg::Q30_ONE - 31'(qs_b[NSTEP] >> SHF);

	always_ff @(posedge clk) begin
		if (en) begin
			s_sf <= 61'(carry_b[NSTEP].x) * 61'(tsf_w);
			c_sf <= uvs_pkg::Q30_ONE - 31'(qc_b[NSTEP] >> CHF);
			quad_sf <= carry_b[NSTEP].quad;
			swap_sf <= carry_b[NSTEP].swap;
		end
	end

	// unfold octant and quadrant
	logic signed [31:0] sa_w;
	logic signed [31:0] ca_w;

	always_comb begin
		if (swap_sf) begin
			sa_w = signed'({1'b0, c_sf});
			ca_w = signed'({2'b00, s_sf[59:30]});
		end else begin
			sa_w = signed'({2'b00, s_sf[59:30]});
			ca_w = signed'({1'b0, c_sf});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_sf)
				2'd0: begin
					sin_q <= sa_w;
					cos_q <= ca_w;
				end
				2'd1: begin
					sin_q <= ca_w;
					cos_q <= -sa_w;
				end
				2'd2: begin
					sin_q <= -sa_w;
					cos_q <= -ca_w;
				end
				default: begin
					sin_q <= -ca_w;
					cos_q <= sa_w;
				end
			endcase
		end
	end

endmodule

/* src/uvs_checker.sv */
`include "assert_macros.svh"

module uvs_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic [uvs_pkg::VTX_W-1:0] vertex_number,
	input logic signed [uvs_pkg::POS_W-1:0] pos_x,
	input logic signed [uvs_pkg::NRM_W-1:0] norm_x,
	input logic last_vertex,
	input logic index_error
);

	// stalled vertex holds
	`ASSERT_STD(a_stall_hold, valid && !ready |=> valid && $stable(vertex_number), "vertex changed under stall")

	// rejected request: single zero vertex
	`ASSERT_STD(a_err_zero, valid && index_error |-> last_vertex && (vertex_number == 3'd0) && (pos_x == 15'sd0) && (norm_x == 16'sd0), "bad rejected-request vertex")

	// last flag sits on corner five
	`ASSERT_STD(a_last_five, valid && !index_error |-> (last_vertex == (vertex_number == uvs_pkg::VTX_LAST)), "last flag misplaced")

	// corners of one tile come out back to back and in order
	`ASSERT_STD(a_seq, valid && ready && !last_vertex |=> valid && (vertex_number == 3'($past(vertex_number) + 3'd1)), "vertex sequence broken")

endmodule

bind uv_sphere_tile_vertex_generator_unit uvs_checker u_uvs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.valid(vertex.valid),
	.ready(vertex.ready),
	.vertex_number(vertex.vertex_number),
	.pos_x(vertex.pos_x),
	.norm_x(vertex.norm_x),
	.last_vertex(vertex.last_vertex),
	.index_error(vertex.index_error)
);
